/* design/cfed_pkg.sv */
// Package for the CFAR energy detector: field widths, fixed constants,
// the sequencer state type and the divider status bundle.
// No dependencies; every other design file refers to it by scoped names.
package cfed_pkg;

    localparam int SAMPLE_W  = 16;   // width of the sample field
    localparam int ENERGY_W  = 31;   // width of a squared sample
    localparam int THRESH_W  = 39;   // width of the threshold field
    localparam int SCALE_W   = 16;   // width of the Q8.8 scale register
    localparam int FRAC_BITS = 8;    // fractional bits of the scale

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1179;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SWEEP,
        ST_TAIL,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } cfed_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cfed_div_stat_t;

endpackage

/* design/cfed_in_if.sv */
// Input stream interface of the CFAR energy detector: valid/ready and one sample word.
// Depends on cfed_pkg for the field widths.
interface cfed_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [cfed_pkg::SAMPLE_W-1:0] sample;
    logic                                last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* design/cfed_out_if.sv */
// Result stream interface of the CFAR energy detector: valid/ready and one result word.
// Depends on cfed_pkg for the field widths.
interface cfed_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfed_pkg::ENERGY_W-1:0] cell_energy;
    logic [cfed_pkg::THRESH_W-1:0] threshold;
    logic                          detected;
    logic                          last_out;

    modport source (output valid, output cell_energy, output threshold,
                    output detected, output last_out, input ready);
    modport sink   (input valid, input cell_energy, input threshold,
                    input detected, input last_out, output ready);
endinterface

/* design/cfed_divider.sv */
// Restoring divider of the CFAR energy detector, one quotient bit per cycle.
// Depends on cfed_pkg for the status bundle.
module cfed_divider #(
    parameter int DIVIDEND_W = 46,
    parameter int DIVISOR_W  = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DIVIDEND_W-1:0]          dividend,
    input  logic [DIVISOR_W-1:0]           divisor,
    output logic [DIVIDEND_W-1:0]          quotient,
    output cfed_pkg::cfed_div_stat_t       stat
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  fits;

    // The dividend shifts out at the top while quotient bits shift in below.
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider reports done while still busy");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while a division is running");

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && step_reg == STEP_W'(DIVIDEND_W - 1)) |=> done_reg)
        else $error("divider missed its done pulse after the final step");

endmodule

/* design/cfar_energy_detector_core.sv */
// Cell-averaging CFAR energy detector, top level; uses cfed_pkg, the interfaces, cfed_divider.
// Each cell's result passes START, SWEEP over hi+1 cells (hi = 2*(WIN_CELLS/2) once the
// record is long), TAIL, MUL, the divider states DIV_GO and DIV_WAIT (skipped with no
// reference cells) and FINISH, which holds while the result register is stalled.
// A sample word is taken only when idle, so none is taken while a job or a flush runs; a
// last sample flushes up to WIN_CELLS/2+1 words. Reset zeroes count, pointer; scale = 1179.
module cfar_energy_detector_core #(
    parameter int WIN_CELLS   = 64,
    parameter int GUARD_CELLS = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [cfed_pkg::SCALE_W-1:0]   cfg_wr_data,
    cfed_in_if.sink                        samples,
    cfed_out_if.source                     results
);

    // Geometry of the window and of the energy memory.
    localparam int HALF_WIN   = WIN_CELLS / 2;
    localparam int GUARD_HALF = GUARD_CELLS / 2;
    localparam int DEPTH      = WIN_CELLS + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DW         = $clog2(WIN_CELLS + 1);
    localparam int GW         = DW + 5;
    localparam int REF_W      = DW;
    localparam int SUM_W      = cfed_pkg::ENERGY_W + REF_W;
    localparam int PROD_W     = SUM_W + cfed_pkg::SCALE_W;
    localparam int QUO_W      = PROD_W - cfed_pkg::FRAC_BITS;
    localparam int EFF_BITS   = (SAMPLE_BITS < cfed_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                   : cfed_pkg::SAMPLE_W;

    cfed_pkg::cfed_state_t state_reg, state_next;

    // Configuration and record bookkeeping.
    logic [cfed_pkg::SCALE_W-1:0]  scale_reg;
    logic [ADDR_W-1:0]             head_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          flush_reg;

    // The current job: the cell under test sits c_reg samples behind the newest one.
    logic [DW-1:0]                 c_reg;
    logic [DW-1:0]                 hi_reg;
    logic [DW-1:0]                 d_reg;
    logic [ADDR_W-1:0]             addr_reg;

    // Read pipeline of the sweep and the accumulators.
    logic                          rd_valid_reg;
    logic                          rd_ref_reg;
    logic                          rd_cut_reg;
    logic [cfed_pkg::ENERGY_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [REF_W-1:0]              refs_reg;
    logic [cfed_pkg::ENERGY_W-1:0] cut_energy_reg;
    logic [PROD_W-1:0]             prod_reg;

    // Output register.
    logic                          out_valid_reg;
    logic [cfed_pkg::ENERGY_W-1:0] out_energy_reg;
    logic [cfed_pkg::THRESH_W-1:0] out_thresh_reg;
    logic                          out_det_reg;
    logic                          out_last_reg;

    logic [cfed_pkg::ENERGY_W-1:0] energy_line [DEPTH];

    // Combinational helpers.
    logic                          in_fire;
    logic                          out_fire;
    logic                          slot_free;
    logic                          more_jobs;
    logic                          div_start;
    logic [QUO_W-1:0]              quotient;
    cfed_pkg::cfed_div_stat_t      div_stat;

    logic signed [EFF_BITS-1:0]    sample_eff;
    logic [EFF_BITS-1:0]           mag;
    logic [31:0]                   energy_wide;
    logic [cfed_pkg::ENERGY_W-1:0] energy;
    logic [ADDR_W-1:0]             head_inc;
    logic [CNT_W-1:0]              cnt_inc;
    logic [CNT_W-1:0]              cnt_inc_m1;
    logic [DW-1:0]                 start_c;
    logic [CNT_W:0]                span_hi;
    logic [CNT_W:0]                rec_hi;
    logic [DW-1:0]                 hi_calc;
    logic [DW-1:0]                 cell_gap;
    logic                          is_guard;
    logic [ADDR_W-1:0]             addr_dec;
    logic [cfed_pkg::THRESH_W-1:0] thresh_calc;
    logic                          det_calc;

    assign in_fire   = samples.valid && samples.ready;
    assign out_fire  = results.valid && results.ready;
    assign slot_free = !out_valid_reg || results.ready;
    assign more_jobs = flush_reg && (c_reg != '0);

    // Only the low sample bits are used, sign-extended from that width.
    // The magnitude of the most negative value still fits as an unsigned word.
    assign sample_eff  = samples.sample[EFF_BITS-1:0];
    assign mag         = sample_eff[EFF_BITS-1] ? (~sample_eff + EFF_BITS'(1)) : sample_eff;
    assign energy_wide = 32'(mag) * 32'(mag);
    assign energy      = energy_wide[cfed_pkg::ENERGY_W-1:0];

    assign head_inc   = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
    assign cnt_inc    = (cnt_reg < CNT_W'(DEPTH)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign cnt_inc_m1 = cnt_inc - CNT_W'(1);

    // A plain sample tests the cell half a window back. A last sample starts the
    // flush with the oldest pending cell of the record and works towards the newest.
    always_comb
    begin
        if (!samples.last)
            start_c = DW'(HALF_WIN);
        else if (cnt_inc_m1 < CNT_W'(HALF_WIN))
            start_c = DW'(cnt_inc_m1);
        else
            start_c = DW'(HALF_WIN);
    end

    // The window never reaches past the start of the record; its near end is always
    // the newest sample, because the cell under test is at most half a window back.
    assign span_hi = (CNT_W + 1)'(c_reg) + (CNT_W + 1)'(HALF_WIN);
    assign rec_hi  = (CNT_W + 1)'(cnt_reg) - (CNT_W + 1)'(1);
    assign hi_calc = (span_hi < rec_hi) ? DW'(span_hi) : DW'(rec_hi);

    assign cell_gap = (d_reg >= c_reg) ? d_reg - c_reg : c_reg - d_reg;
    assign is_guard = (GW'(cell_gap) <= GW'(GUARD_HALF));
    assign addr_dec = (addr_reg == '0) ? ADDR_W'(DEPTH - 1) : addr_reg - ADDR_W'(1);

    // With no reference cells the threshold and the flag both stay at zero.
    assign thresh_calc = (refs_reg == '0) ? '0 : quotient[cfed_pkg::THRESH_W-1:0];
    assign det_calc    = (refs_reg != '0) &&
                         (cfed_pkg::THRESH_W'(cut_energy_reg) > thresh_calc);

    assign samples.ready = (state_reg == cfed_pkg::ST_IDLE);

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cfed_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and the divider start strobe.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            cfed_pkg::ST_IDLE:
            begin
                if (in_fire && (samples.last || (cnt_inc > CNT_W'(HALF_WIN))))
                    state_next = cfed_pkg::ST_START;
            end
            cfed_pkg::ST_START:
            begin
                state_next = cfed_pkg::ST_SWEEP;
            end
            cfed_pkg::ST_SWEEP:
            begin
                if (d_reg == hi_reg)
                    state_next = cfed_pkg::ST_TAIL;
            end
            cfed_pkg::ST_TAIL:
            begin
                state_next = cfed_pkg::ST_MUL;
            end
            cfed_pkg::ST_MUL:
            begin
                if (refs_reg == '0)
                    state_next = cfed_pkg::ST_FINISH;
                else
                    state_next = cfed_pkg::ST_DIV_GO;
            end
            cfed_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = cfed_pkg::ST_DIV_WAIT;
            end
            cfed_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = cfed_pkg::ST_FINISH;
            end
            cfed_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = more_jobs ? cfed_pkg::ST_START : cfed_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cfed_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers: scale, write pointer, record count, read pipeline valid
    // and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= cfed_pkg::SCALE_RESET;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                scale_reg <= cfg_wr_data;

            if (in_fire)
            begin
                head_reg <= head_inc;
                cnt_reg  <= cnt_inc;
            end
            else if (state_reg == cfed_pkg::ST_FINISH && slot_free &&
                     flush_reg && !more_jobs)
            begin
                // The record ends with its newest cell; the next one starts empty.
                cnt_reg <= '0;
            end

            rd_valid_reg <= (state_reg == cfed_pkg::ST_SWEEP);

            if (state_reg == cfed_pkg::ST_FINISH && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Job and sweep datapath. Nothing here needs a reset: every field is loaded
    // before the sequencer reads it.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            flush_reg <= samples.last;
            c_reg     <= start_c;
        end

        if (state_reg == cfed_pkg::ST_START)
        begin
            d_reg    <= '0;
            addr_reg <= head_reg;
            hi_reg   <= hi_calc;
            sum_reg  <= '0;
            refs_reg <= '0;
        end

        if (state_reg == cfed_pkg::ST_SWEEP)
        begin
            rd_ref_reg <= !is_guard;
            rd_cut_reg <= (d_reg == c_reg);
            d_reg      <= d_reg + DW'(1);
            addr_reg   <= addr_dec;
        end

        // Data read by the previous sweep cycle lands here; the cell under test is itself a
        // guard cell, so it is captured but never summed.
        if (rd_valid_reg)
        begin
            if (rd_ref_reg)
            begin
                sum_reg  <= sum_reg + SUM_W'(rd_data_reg);
                refs_reg <= refs_reg + REF_W'(1);
            end
            if (rd_cut_reg)
                cut_energy_reg <= rd_data_reg;
        end

        if (state_reg == cfed_pkg::ST_MUL)
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(scale_reg);

        if (state_reg == cfed_pkg::ST_FINISH && slot_free)
        begin
            out_energy_reg <= cut_energy_reg;
            out_thresh_reg <= thresh_calc;
            out_det_reg    <= det_calc;
            out_last_reg   <= flush_reg && (c_reg == '0);
            if (more_jobs)
                c_reg <= c_reg - DW'(1);
        end
    end

    // Energy memory. Writes happen only on an accepted sample, which the sequencer
    // allows only when idle, so a sweep never reads an entry in the cycle it is written.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            energy_line[head_inc] <= energy;
        rd_data_reg <= energy_line[addr_reg];
    end

    // The scaled sum is divided by 256 first and then by the reference count,
    // which gives the same floor as one division by their product.
    cfed_divider #(
        .DIVIDEND_W (QUO_W),
        .DIVISOR_W  (REF_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[PROD_W-1:cfed_pkg::FRAC_BITS]),
        .divisor  (refs_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign results.valid       = out_valid_reg;
    assign results.cell_energy = out_energy_reg;
    assign results.threshold   = out_thresh_reg;
    assign results.detected    = out_det_reg;
    assign results.last_out    = out_last_reg;

    a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfed_pkg::ST_FINISH && slot_free) |=> out_valid_reg)
        else $error("finished result word was not loaded into the output register");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfed_pkg::ST_SWEEP) |-> (d_reg <= hi_reg))
        else $error("sweep ran past the end of the window");

    a_div_has_refs: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (refs_reg != '0) && !div_stat.busy)
        else $error("division started with no reference cells or while busy");

    a_job_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfed_pkg::ST_START) |-> (cnt_reg != '0) && (CNT_W'(c_reg) < cnt_reg))
        else $error("job started for a cell outside the current record");

endmodule
